### hdl/tpic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tpic_pkg;

  localparam int PAL_ENTRIES_DEF = 256;
  localparam int PIXEL_W         = 16;
  localparam int COUNT_W         = 9;
  localparam int RGB_W           = 24;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_TARGET_MODE  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_ALPHA = 1'd1;

  localparam logic [1:0] MODE_INDEXED = 2'd0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       first_pixel;
  } pixel_in_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_value;
    logic               new_color;
    logic               palette_overflow;
    logic [COUNT_W-1:0] color_count;
  } pixel_out_t;

  // Requests from the top level to the palette unit.
  typedef struct packed {
    logic start;
    logic clear;
  } pal_req_t;

  // Outcome of one palette search.
  typedef struct packed {
    logic               done;
    logic               appended;
    logic [PIXEL_W-1:0] index;
  } pal_res_t;

  typedef struct packed {
    logic               overflow;
    logic [COUNT_W-1:0] count;
  } pal_status_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_SEARCH,
    T_DELIVER
  } top_state_t;

  typedef enum logic {
    P_IDLE,
    P_SEARCH
  } pal_state_t;

  function automatic logic [PIXEL_W-1:0] pack_555(input pixel_in_t px, input logic alpha_src);
    logic alpha_bit;
    begin
      alpha_bit = alpha_src && (px.alpha != 8'd0);
      pack_555  = {alpha_bit, px.blue[7:3], px.green[7:3], px.red[7:3]};
    end
  endfunction

endpackage

`default_nettype wire

### hdl/tpic_palette.sv
`timescale 1ns / 1ps
`default_nettype none

module tpic_palette import tpic_pkg::*; #(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pal_req_t          req,
  input  wire logic [RGB_W-1:0]  rgb,
  output pal_res_t               res,
  output pal_status_t            status
);

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);

  pal_state_t state_r, state_nxt;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic             cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [RGB_W-1:0] rgb_r;
  logic [RGB_W-1:0] rd_data_r;

  logic [RGB_W-1:0] mem [PALETTE_ENTRIES];

  logic hit;
  logic all_issued;
  logic room;
  logic rd_en;
  logic finish;
  logic append;
  logic set_ovf;

  // The comparator looks at the entry read in the previous cycle.
  assign hit        = cmp_vld_r && (rd_data_r == rgb_r);
  assign all_issued = (issue_r == cnt_r);
  assign room       = (cnt_r < CNT_W'(PALETTE_ENTRIES));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      P_IDLE: begin
        if (req.start) state_nxt = P_SEARCH;
      end
      P_SEARCH: begin
        if (hit || all_issued) state_nxt = P_IDLE;
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    finish  = 1'b0;
    unique case (state_r)
      P_IDLE: begin
        rd_en  = 1'b0;
        finish = 1'b0;
      end
      P_SEARCH: begin
        rd_en  = !all_issued && !hit;
        finish = hit || all_issued;
      end
      default: begin
        rd_en  = 1'b0;
        finish = 1'b0;
      end
    endcase
    append  = finish && !hit && room;
    set_ovf = finish && !hit && !room;

    res.done     = finish;
    res.appended = append;
    if (hit) begin
      res.index = PIXEL_W'(cmp_idx_r);
    end else if (append) begin
      res.index = PIXEL_W'(cnt_r[IDX_W-1:0]);
    end else begin
      res.index = '0;
    end

    status.overflow = ovf_r;
    status.count    = COUNT_W'(cnt_r);
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    issue_nxt   = issue_r;
    cmp_vld_nxt = rd_en;
    cmp_idx_nxt = issue_r[IDX_W-1:0];
    if (req.clear) begin
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else if (append) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (set_ovf) begin
      ovf_nxt = 1'b1;
    end
    if (req.start) begin
      issue_nxt = '0;
    end else if (rd_en) begin
      issue_nxt = issue_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= P_IDLE;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      issue_r   <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      issue_r   <= issue_nxt;
      cmp_vld_r <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= cmp_idx_nxt;
    if (req.start) begin
      rgb_r <= rgb;
    end
  end

  // Palette memory: one write port for appends, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (append) begin
      mem[cnt_r[IDX_W-1:0]] <= rgb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[issue_r[IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

### hdl/texture_palette_index_converter.sv
`timescale 1ns / 1ps
`default_nettype none

// Converts one RGB(A) 8-bit pixel per transfer into either a palette index or a 16-bit
// 5:5:5 colour with bit 15 as the alpha flag. In indexed mode the pixel is compared against
// the palette entries one per cycle through a single memory read port and one 24-bit
// comparator; the scan stops at the first match, or after all entries in use when the
// colour is new. In the packed modes no search is made. The input is stalled while a
// pixel is being worked on; a finished result may wait in the output register while
// the next pixel is taken. The palette memory needs no clearing after reset.
// Configuration must be written only while the block is idle; the block itself does not
// enforce this.

module texture_palette_index_converter import tpic_pkg::*; #(
  parameter int PALETTE_ENTRIES = PAL_ENTRIES_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,

  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire pixel_in_t              in_data,

  output logic                        out_valid,
  input  wire logic                   out_stall,
  output pixel_out_t                  out_data,

  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  top_state_t state_r, state_nxt;

  logic [1:0]         mode_r;
  logic               alpha_src_r;

  logic [PIXEL_W-1:0] pend_value_r, pend_value_nxt;
  logic               pend_new_r, pend_new_nxt;

  logic               out_valid_r, out_valid_nxt;
  pixel_out_t         out_data_r;

  logic               in_xfer;
  logic               indexed;
  logic               load_out;

  pal_req_t           pal_req;
  pal_res_t           pal_res;
  pal_status_t        pal_status;

  tpic_palette #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_palette (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (pal_req),
    .rgb    ({in_data.blue, in_data.green, in_data.red}),
    .res    (pal_res),
    .status (pal_status)
  );

  assign indexed = (mode_r == MODE_INDEXED);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE: begin
        if (in_valid) state_nxt = indexed ? T_SEARCH : T_DELIVER;
      end
      T_SEARCH: begin
        if (pal_res.done) state_nxt = T_DELIVER;
      end
      T_DELIVER: begin
        if (!out_valid_r || !out_stall) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    load_out = 1'b0;
    unique case (state_r)
      T_IDLE:    in_stall = 1'b0;
      T_SEARCH:  in_stall = 1'b1;
      T_DELIVER: load_out = !out_valid_r || !out_stall;
      default:   in_stall = 1'b1;
    endcase
    in_xfer       = in_valid && !in_stall;
    pal_req.start = in_xfer && indexed;
    pal_req.clear = in_xfer && in_data.first_pixel;

    pend_value_nxt = pend_value_r;
    pend_new_nxt   = pend_new_r;
    if (in_xfer && !indexed) begin
      pend_value_nxt = pack_555(in_data, alpha_src_r);
      pend_new_nxt   = 1'b0;
    end else if (state_r == T_SEARCH && pal_res.done) begin
      pend_value_nxt = pal_res.index;
      pend_new_nxt   = pal_res.appended;
    end

    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      mode_r      <= MODE_INDEXED;
      alpha_src_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET_MODE:  mode_r      <= cfg_data[1:0];
          REG_SOURCE_ALPHA: alpha_src_r <= cfg_data[0];
          default:          mode_r      <= mode_r;
        endcase
      end
    end
  end

  // Palette status is stable once the search has finished, so it is sampled here.
  always_ff @(posedge clk) begin
    pend_value_r <= pend_value_nxt;
    pend_new_r   <= pend_new_nxt;
    if (load_out) begin
      out_data_r.pixel_value      <= pend_value_r;
      out_data_r.new_color        <= pend_new_r;
      out_data_r.palette_overflow <= pal_status.overflow;
      out_data_r.color_count      <= pal_status.count;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
